// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// checked with reset held off
`define BFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define BFS_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFS_ASSERT(lbl, prop, msg)
`define BFS_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// File: src/bfs_pkg.sv
// ----------------------------------------------------------------------------
// bfs_pkg
// types and constants shared by the backward fast search matcher
// ----------------------------------------------------------------------------
`default_nettype none

package bfs_pkg;

  localparam int PAT_MAX = 32;
  localparam int PAT_AW  = 5;
  localparam int LEN_W   = 6;
  localparam int CH_W    = 8;
  localparam int GS_AW   = PAT_AW + CH_W;
  localparam int GS_DEPTH = PAT_MAX * 256;
  localparam int CNT_W   = 32;
  localparam int S_W     = CNT_W + 1;

  typedef logic [CH_W-1:0]   char_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [PAT_AW-1:0] pidx_t;
  typedef logic [GS_AW-1:0]  gs_addr_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_BINIT, ST_CLR, ST_BCW, ST_CH1I, ST_CH1, ST_LINIT, ST_LSTEP,
    ST_LGSW, ST_LEND, ST_FRD, ST_FWR, ST_SCHK, ST_SBCK, ST_SVER, ST_SGSA,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    PS_J, PS_I, PS_MLAST, PS_LTAIL, PS_ITAIL, PS_ZERO, PS_K
  } pat_sel_t;

  typedef enum logic [1:0] {
    GS_BUILD, GS_FIRST, GS_SEARCH
  } gs_sel_t;

  typedef struct packed {
    logic     pat_wr;
    logic     txt_wr;
    logic     b_init;
    logic     clr_step;
    logic     bcw_step;
    logic     ch1_init;
    logic     ch1_step;
    logic     len_init;
    logic     len_step;
    logic     gs_wr;
    logic     len_end;
    logic     first_wr;
    logic     s_add_bc;
    logic     k_init;
    logic     k_dec;
    logic     match;
    logic     s_add_gs;
    logic     s_fin;
    logic     emit;
    pat_sel_t pat_sel;
    gs_sel_t  gs_sel;
  } bfs_cmd_t;

  typedef struct packed {
    logic pat_ready;
    logic count_full;
    logic clr_last;
    logic bcw_last;
    logic i_neg;
    logic i_ge;
    logic m_one;
    logic len_last;
    logic s_le_t;
    logic bc_nz;
    logic k_zero;
    logic ver_eq;
    logic found;
    logic out_busy;
  } bfs_sts_t;

endpackage

`default_nettype wire

// File: src/bfs_stream_if.sv
// ----------------------------------------------------------------------------
// bfs stream interfaces
// valid/ready channels for input items and match results
// ----------------------------------------------------------------------------
`default_nettype none

interface bfs_in_if;
  import bfs_pkg::*;
  logic  valid;
  logic  ready;
  logic  op;
  char_t data_byte;
  logic  final_pattern_byte;
  modport source (output valid, output op, output data_byte,
                  output final_pattern_byte, input ready);
  modport sink (input valid, input op, input data_byte,
                input final_pattern_byte, output ready);
endinterface

interface bfs_out_if;
  import bfs_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] match_start;
  modport source (output valid, output match_start, input ready);
  modport sink (input valid, input match_start, output ready);
endinterface

`default_nettype wire

// File: src/bfs_ctrl.sv
// ----------------------------------------------------------------------------
// bfs_ctrl
// sequencer for table build and per-byte search
// ----------------------------------------------------------------------------
`default_nettype none

module bfs_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  input  wire                in_op,
  input  wire                in_final,
  output logic               in_ready,
  input  bfs_pkg::bfs_sts_t  sts,
  output bfs_pkg::bfs_cmd_t  cmd
);
  import bfs_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!in_op) begin
            cmd.pat_wr = 1'b1;
            if (in_final) state_nxt = ST_BINIT;
          end else if (sts.pat_ready && !sts.count_full) begin
            cmd.txt_wr = 1'b1;
            state_nxt  = ST_SCHK;
          end
        end
      end
      ST_BINIT: begin
        cmd.b_init = 1'b1;
        state_nxt  = ST_CLR;
      end
      ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_BCW;
      end
      ST_BCW: begin
        cmd.bcw_step = 1'b1;
        cmd.pat_sel  = PS_J;
        if (sts.bcw_last) state_nxt = ST_CH1I;
      end
      ST_CH1I: begin
        cmd.ch1_init = 1'b1;
        cmd.pat_sel  = PS_MLAST;
        state_nxt    = ST_CH1;
      end
      ST_CH1: begin
        cmd.pat_sel = PS_I;
        if (sts.i_neg) begin
          state_nxt = sts.m_one ? ST_FRD : ST_LINIT;
        end else begin
          cmd.ch1_step = 1'b1;
        end
      end
      ST_LINIT: begin
        cmd.len_init = 1'b1;
        cmd.pat_sel  = PS_LTAIL;
        state_nxt    = ST_LSTEP;
      end
      ST_LSTEP: begin
        cmd.pat_sel = PS_ITAIL;
        cmd.gs_sel  = GS_BUILD;
        if (sts.i_neg) begin
          state_nxt = ST_LEND;
        end else begin
          cmd.len_step = 1'b1;
          if (sts.i_ge) state_nxt = ST_LGSW;
        end
      end
      ST_LGSW: begin
        cmd.gs_wr = 1'b1;
        state_nxt = ST_LSTEP;
      end
      ST_LEND: begin
        cmd.len_end = 1'b1;
        state_nxt   = sts.len_last ? ST_FRD : ST_LINIT;
      end
      ST_FRD: begin
        cmd.pat_sel = PS_ZERO;
        cmd.gs_sel  = GS_FIRST;
        state_nxt   = ST_FWR;
      end
      ST_FWR: begin
        cmd.first_wr = 1'b1;
        cmd.gs_sel   = GS_FIRST;
        state_nxt    = ST_IDLE;
      end
      ST_SCHK: begin
        if (sts.s_le_t) begin
          state_nxt = ST_SBCK;
        end else begin
          cmd.s_fin = 1'b1;
          state_nxt = sts.found ? ST_EMIT : ST_IDLE;
        end
      end
      ST_SBCK: begin
        if (sts.bc_nz) begin
          cmd.s_add_bc = 1'b1;
          state_nxt    = ST_SCHK;
        end else begin
          cmd.k_init = 1'b1;
          state_nxt  = ST_SVER;
        end
      end
      ST_SVER: begin
        cmd.pat_sel = PS_K;
        cmd.gs_sel  = GS_SEARCH;
        if (sts.k_zero) begin
          cmd.match = 1'b1;
          state_nxt = ST_SCHK;
        end else if (sts.ver_eq) begin
          cmd.k_dec = 1'b1;
        end else begin
          state_nxt = ST_SGSA;
        end
      end
      ST_SGSA: begin
        cmd.s_add_gs = 1'b1;
        cmd.gs_sel   = GS_SEARCH;
        state_nxt    = ST_SCHK;
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: src/bfs_datapath.sv
// ----------------------------------------------------------------------------
// bfs_datapath
// pattern and text stores, shift tables, search registers, result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bfs_datapath (
  input  wire                        clk,
  input  wire                        rst_n,
  input  bfs_pkg::char_t             in_data_byte,
  input  bfs_pkg::bfs_cmd_t          cmd,
  output bfs_pkg::bfs_sts_t          sts,
  input  wire                        out_ready,
  output logic                       out_valid,
  output logic [bfs_pkg::CNT_W-1:0]  out_match_start
);
  import bfs_pkg::*;

  // stores
  char_t                     pat_mem [PAT_MAX];
  char_t                     ring_mem [PAT_MAX];
  len_t                      bc_mem [256];
  len_t                      gs_mem [GS_DEPTH];
  len_t                      floor_r [PAT_MAX];
  logic signed [LEN_W-1:0]   chain_r [PAT_MAX];

  // control and working registers
  len_t                      len_r;
  logic                      ready_r;
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          tcur_r;
  logic [S_W-1:0]            s_r;
  len_t                      first_r;
  pidx_t                     j_r;
  logic signed [LEN_W-1:0]   i_r;
  pidx_t                     last_r;
  char_t                     plast_r;
  char_t                     b_r;
  len_t                      lenc_r;
  len_t                      v_r;
  gs_addr_t                  gw_addr_r;
  pidx_t                     k_r;
  gs_addr_t                  clr_cnt_r;
  len_t                      bc_q;
  len_t                      gs_q;
  logic                      found_r;
  logic [CNT_W-1:0]          match_r;
  logic                      out_valid_r;
  logic [CNT_W-1:0]          out_data_r;

  // combinational reads
  pidx_t                     m_m1;
  pidx_t                     row_idx;
  pidx_t                     k_m1;
  logic signed [LEN_W:0]     tail_s;
  pidx_t                     pat_raddr;
  char_t                     pat_rd;
  pidx_t                     ring_raddr;
  char_t                     ring_rd;
  gs_addr_t                  gs_raddr;
  pidx_t                     floor_idx;
  len_t                      floor_rd;
  pidx_t                     chain_raddr;
  logic signed [LEN_W-1:0]   chain_rd;
  len_t                      gs_min;
  len_t                      v_cur;
  len_t                      pat_base;

  assign m_m1    = PAT_AW'(len_r - LEN_W'(1));
  assign row_idx = PAT_AW'(len_r - lenc_r);
  assign k_m1    = k_r - PAT_AW'(1);
  // i - len + 1, signed
  assign tail_s  = $signed({i_r[LEN_W-1], i_r}) - $signed({1'b0, lenc_r})
                   + $signed((LEN_W+1)'(1));
  assign v_cur   = LEN_W'(m_m1 - i_r[PAT_AW-1:0]);

  always_comb begin
    case (cmd.pat_sel)
      PS_J:     pat_raddr = j_r;
      PS_I:     pat_raddr = i_r[PAT_AW-1:0];
      PS_MLAST: pat_raddr = m_m1;
      PS_LTAIL: pat_raddr = row_idx;
      PS_ITAIL: pat_raddr = tail_s[PAT_AW-1:0];
      PS_ZERO:  pat_raddr = '0;
      PS_K:     pat_raddr = k_m1;
      default:  pat_raddr = '0;
    endcase
  end
  assign pat_rd = pat_mem[pat_raddr];

  // ring is read at the shift position, or at the compare point while verifying
  assign ring_raddr = (cmd.pat_sel == PS_K) ? (s_r[PAT_AW-1:0] - len_r[PAT_AW-1:0] + k_r)
                                            : s_r[PAT_AW-1:0];
  assign ring_rd = ring_mem[ring_raddr];

  always_comb begin
    case (cmd.gs_sel)
      GS_BUILD: begin
        gs_raddr  = {row_idx, pat_rd};
        floor_idx = row_idx;
      end
      GS_FIRST: begin
        gs_raddr  = {PAT_AW'(0), pat_rd};
        floor_idx = '0;
      end
      GS_SEARCH: begin
        gs_raddr  = {k_m1, ring_rd};
        floor_idx = k_m1;
      end
      default: begin
        gs_raddr  = '0;
        floor_idx = '0;
      end
    endcase
  end
  assign floor_rd = floor_r[floor_idx];
  assign gs_min   = (gs_q < floor_rd) ? gs_q : floor_rd;

  assign chain_raddr = cmd.len_init ? m_m1 : i_r[PAT_AW-1:0];
  assign chain_rd    = chain_r[chain_raddr];

  assign pat_base = ready_r ? '0 : len_r;

  // bad-character table
  always_ff @(posedge clk) begin
    if (cmd.clr_step && (clr_cnt_r[GS_AW-1:CH_W] == '0)) begin
      bc_mem[clr_cnt_r[CH_W-1:0]] <= len_r;
    end else if (cmd.bcw_step) begin
      bc_mem[pat_rd] <= LEN_W'(m_m1 - j_r);
    end
    bc_q <= bc_mem[ring_rd];
  end

  // good-suffix table, one row per suffix length
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      gs_mem[clr_cnt_r] <= len_r;
    end else if (cmd.gs_wr && (gs_q > v_r)) begin
      gs_mem[gw_addr_r] <= v_r;
    end
    gs_q <= gs_mem[gs_raddr];
  end

  // pattern, ring, chain and row floors
  always_ff @(posedge clk) begin
    if (cmd.pat_wr && (pat_base < LEN_W'(PAT_MAX))) begin
      pat_mem[pat_base[PAT_AW-1:0]] <= in_data_byte;
    end
    if (cmd.txt_wr) begin
      ring_mem[count_r[PAT_AW-1:0]] <= in_data_byte;
    end
    if (cmd.b_init) begin
      for (int n = 0; n < PAT_MAX; n++) begin
        chain_r[n] <= '1;
        floor_r[n] <= len_r;
      end
    end
    if (cmd.ch1_step && (pat_rd == plast_r)) begin
      chain_r[last_r] <= i_r;
    end
    if (cmd.len_step) begin
      if (tail_s[LEN_W]) begin
        chain_r[last_r] <= i_r;
        if (v_cur < floor_r[row_idx]) floor_r[row_idx] <= v_cur;
      end else if (pat_rd == b_r) begin
        chain_r[last_r] <= i_r;
      end
    end
    if (cmd.len_end) begin
      chain_r[last_r] <= '1;
    end
  end

  // build registers
  always_ff @(posedge clk) begin
    if (cmd.b_init) begin
      clr_cnt_r <= '0;
      j_r       <= '0;
    end
    if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + GS_AW'(1);
    if (cmd.bcw_step) j_r <= j_r + PAT_AW'(1);
    if (cmd.ch1_init) begin
      last_r  <= m_m1;
      plast_r <= pat_rd;
      i_r     <= $signed(LEN_W'(len_r - LEN_W'(2)));
      lenc_r  <= LEN_W'(2);
    end
    if (cmd.ch1_step) begin
      if (pat_rd == plast_r) last_r <= i_r[PAT_AW-1:0];
      i_r <= i_r - LEN_W'(1);
    end
    if (cmd.len_init) begin
      last_r <= m_m1;
      b_r    <= pat_rd;
      i_r    <= chain_rd;
    end
    if (cmd.len_step) begin
      if (tail_s[LEN_W] || (pat_rd == b_r)) last_r <= i_r[PAT_AW-1:0];
      v_r       <= v_cur;
      gw_addr_r <= gs_raddr;
      i_r       <= chain_rd;
    end
    if (cmd.len_end) lenc_r <= lenc_r + LEN_W'(1);
    if (cmd.first_wr) first_r <= gs_min;
    if (cmd.txt_wr) tcur_r <= count_r;
    if (cmd.k_init) k_r <= m_m1;
    if (cmd.k_dec) k_r <= k_m1;
    if (cmd.match) match_r <= s_r[CNT_W-1:0] - CNT_W'(len_r) + CNT_W'(1);
    if (cmd.emit) out_data_r <= match_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      ready_r     <= 1'b0;
      count_r     <= '0;
      s_r         <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.pat_wr) begin
        ready_r <= 1'b0;
        count_r <= '0;
        s_r     <= '0;
        len_r   <= (pat_base < LEN_W'(PAT_MAX)) ? pat_base + LEN_W'(1) : pat_base;
      end
      if (cmd.first_wr) begin
        ready_r <= 1'b1;
        s_r     <= S_W'(m_m1);
      end
      if (cmd.txt_wr) begin
        count_r <= count_r + CNT_W'(1);
        found_r <= 1'b0;
      end
      if (cmd.s_add_bc) s_r <= s_r + S_W'(bc_q);
      if (cmd.match) begin
        found_r <= 1'b1;
        s_r     <= s_r + S_W'(first_r);
      end
      if (cmd.s_add_gs) s_r <= s_r + S_W'(gs_min);
      if (cmd.s_fin && s_r[CNT_W]) s_r <= S_W'({CNT_W{1'b1}});
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.pat_ready  = ready_r;
  assign sts.count_full = (count_r == {CNT_W{1'b1}});
  assign sts.clr_last   = (clr_cnt_r == {m_m1, {CH_W{1'b1}}});
  assign sts.bcw_last   = (j_r == m_m1);
  assign sts.i_neg      = i_r[LEN_W-1];
  assign sts.i_ge       = ~tail_s[LEN_W];
  assign sts.m_one      = (len_r == LEN_W'(1));
  assign sts.len_last   = (lenc_r == len_r);
  assign sts.s_le_t     = (s_r <= {1'b0, tcur_r});
  assign sts.bc_nz      = (bc_q != '0);
  assign sts.k_zero     = (k_r == '0);
  assign sts.ver_eq     = (pat_rd == ring_rd);
  assign sts.found      = found_r;
  assign sts.out_busy   = out_valid_r && !out_ready;

  assign out_valid       = out_valid_r;
  assign out_match_start = out_data_r;

  `BFS_ASSERT(a_count_step, cmd.txt_wr |=> (count_r == $past(count_r) + 32'd1), "text count did not advance")
  `BFS_ASSERT(a_text_ready, cmd.txt_wr |-> ready_r, "text taken before pattern ready")
  `BFS_ASSERT(a_clr_range, cmd.clr_step |-> (clr_cnt_r[GS_AW-1:CH_W] < len_r), "clear ran past last row")
  `BFS_ASSERT(a_emit_free, cmd.emit |-> !(out_valid_r && !out_ready), "result overwrote pending item")
  `BFS_ASSERT_NR(a_rst_out, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule

`default_nettype wire

// File: src/backward_fast_search_matcher_top.sv
// ----------------------------------------------------------------------------
// backward_fast_search_matcher_top
// streaming exact string matcher, backward fast search
// ----------------------------------------------------------------------------
// Load a pattern as op=0 items (up to 32 bytes kept, later ones dropped), the
// last one flagged final_pattern_byte; then stream text as op=1 items and get
// the zero-based start of each occurrence on the result channel, at most one
// per text byte. Any pattern item restarts the text count. After the final
// pattern byte the block is busy building its tables: it clears the
// good-suffix rows and bad-character table, fills the bad-character table,
// builds the suffix chain, then lowers the good-suffix entries, and last
// stores the shift used after a match. A text item then runs the shift loop
// on the bad-character table and, for each candidate, a backward verify and
// a good-suffix shift lookup; the backward verify walks one byte per cycle.
// Text sent before a pattern is complete is taken and dropped. A result
// waits in an output register; the block stalls only if a second result is
// due before the first is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module backward_fast_search_matcher_top (
  input  wire        clk,
  input  wire        rst_n,
  bfs_in_if.sink     in_ch,
  bfs_out_if.source  out_ch
);
  import bfs_pkg::*;

  // command and status between sequencer and datapath
  bfs_cmd_t cmd;
  bfs_sts_t sts;

  // sequencer: build phases, skip loop, backward verify, result hand-off
  bfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_final (in_ch.final_pattern_byte),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: stores, shift tables, shift position and output register
  bfs_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data_byte    (in_ch.data_byte),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_match_start (out_ch.match_start)
  );

endmodule

`default_nettype wire
